FILE: hdl/stereo_volume_pan_mixer_assert.svh
// Assertion macros for the stereo volume and pan mixer.
// Included by the top level; depends on nothing else.
`ifndef STEREO_VOLUME_PAN_MIXER_ASSERT_SVH
`define STEREO_VOLUME_PAN_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SVPM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stereo_volume_pan_mixer: assertion violated");

// Next-cycle implication, disabled while reset is high.
`define SVPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stereo_volume_pan_mixer: assertion violated");

`endif

FILE: hdl/svpm_pkg.sv
// Shared types, constants and the volume table generator of the mixer.
// Used by svpm_ctrl, svpm_datapath and stereo_volume_pan_mixer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svpm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int VOLIDX_W    = 5;
  localparam int VOL_W       = 15;
  localparam int SIDE_W      = 2;
  localparam int NUM_VOL     = 32;
  localparam int MAG_W       = 30;
  localparam int RCP_W       = 32;
  localparam int SUM_W       = 32;
  localparam int PROD_W      = SUM_W + VOL_W;
  localparam int QUO_W       = 24;
  localparam int BAL_W       = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int ITEM_W      = SAMPLE_W + VOLIDX_W;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = SIDE_W + 1;
  localparam int OUT_TDATA_W = 2 * SAMPLE_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MASTER_VOLUME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BALANCE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MUTE_ALL      = 2'd2;

  localparam logic [VOLIDX_W-1:0] MASTER_VOLUME_RESET = 5'd29;

  // Side codes; the unused code routes to both sides.
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

  localparam logic signed [BAL_W-1:0] BAL_MAX = 4'sd6;
  localparam logic signed [BAL_W-1:0] BAL_MIN = -4'sd6;
  localparam logic [2:0] BAL_STEPS = 3'd6;

  // x / 6 for x below 512 as (x * 171) >> 10.
  localparam logic [15:0] DIV6_RECIP = 16'd171;
  localparam int DIV6_SHIFT = 10;

  // One 1.5 dB step is a ratio of 1.188502227.
  localparam longint unsigned VOL_STEP_NUM  = 64'd1000000000;
  localparam longint unsigned VOL_STEP_DEN  = 64'd1188502227;
  localparam longint unsigned VOL_STEP_HALF = 64'd594251113;

  typedef struct packed {
    logic load_item;
    logic load_sum;
    logic side_r;
    logic mul;
    logic div;
    logic mst;
    logic acc;
    logic store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_item;
    logic out_stall;
  } stat_t;

  typedef logic [NUM_VOL-1:0][VOL_W-1:0] vol_tab_t;

  // Builds the log volume table at elaboration: the top entry is full scale and
  // each step down divides by the step ratio in Q16, rounding to nearest.
  function automatic vol_tab_t vol_table(input int unsigned full_scale);
    vol_tab_t tab;
    longint unsigned acc;
    longint unsigned val;
    tab = '0;
    acc = 64'(full_scale) << 16;
    for (int k = NUM_VOL - 1; k >= 1; k--) begin
      val = (acc + 64'd32768) >> 16;
      tab[k] = VOL_W'(val);
      acc = (acc * VOL_STEP_NUM + VOL_STEP_HALF) / VOL_STEP_DEN;
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/svpm_ctrl.sv
// Sequencer of the mixer: walks each item through multiply, divide and
// accumulate, and runs the master scaling of both sides on the last item.
// Depends on svpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire svpm_pkg::stat_t stat,
  output svpm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_MLOAD,
    ST_MMUL,
    ST_MDIV,
    ST_MSTORE,
    ST_EMIT
  } state_t;

  state_t state;
  logic   side_r;
  logic   accept;

  // A new item may enter while the previous one is being accumulated.
  assign s_tready = (state == ST_IDLE) || ((state == ST_ACC) && !stat.last_item);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd           = '0;
    cmd.load_item = accept;
    cmd.side_r    = side_r;
    unique case (state)
      ST_MUL:    cmd.mul   = 1'b1;
      ST_DIV:    cmd.div   = 1'b1;
      ST_ACC:    cmd.acc   = 1'b1;
      ST_MLOAD:  cmd.load_sum = 1'b1;
      ST_MMUL:   cmd.mul   = 1'b1;
      ST_MDIV: begin
        cmd.div = 1'b1;
        cmd.mst = 1'b1;
      end
      ST_MSTORE: cmd.store = 1'b1;
      ST_EMIT:   cmd.emit  = !stat.out_stall;
      ST_IDLE:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      side_r <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_MUL;
        end
        ST_MUL:  state <= ST_DIV;
        ST_DIV:  state <= ST_ACC;
        ST_ACC: begin
          if (stat.last_item) begin
            side_r <= 1'b0;
            state  <= ST_MLOAD;
          end else if (accept) begin
            state <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MLOAD: state <= ST_MMUL;
        ST_MMUL:  state <= ST_MDIV;
        ST_MDIV:  state <= ST_MSTORE;
        ST_MSTORE: begin
          if (!side_r) begin
            side_r <= 1'b1;
            state  <= ST_MLOAD;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!stat.out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/svpm_datapath.sv
// Datapath of the mixer: operand registers, the scaling multiplier, the shared
// reciprocal divider, the left and right sums and the output register.
// Depends on svpm_pkg; driven by svpm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module svpm_datapath #(
  parameter int unsigned FULL_SCALE = 32767
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire svpm_pkg::cmd_t                    cmd,
  output svpm_pkg::stat_t                        stat,
  input  wire logic [svpm_pkg::ITEM_W-1:0]       item_data,
  input  wire logic [svpm_pkg::IN_TUSER_W-1:0]   item_user,
  input  wire logic                              item_last,
  input  wire logic [svpm_pkg::VOLIDX_W-1:0]     master_volume,
  input  wire logic signed [svpm_pkg::BAL_W-1:0] balance,
  input  wire logic                              mute_all,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [svpm_pkg::OUT_TDATA_W-1:0]       m_tdata
);

  localparam int P_W = svpm_pkg::PROD_W;
  localparam int Q_W = svpm_pkg::QUO_W;
  localparam int R_W = svpm_pkg::RCP_W;
  localparam int M_W = svpm_pkg::MAG_W;
  localparam int S_W = svpm_pkg::SUM_W;
  localparam int D_W = svpm_pkg::SAMPLE_W;
  localparam int X_W = M_W + R_W;

  localparam svpm_pkg::vol_tab_t VOL_TAB = svpm_pkg::vol_table(FULL_SCALE);

  // Exact division of a value below 2^MAG_W by a constant: multiply by the
  // rounded-up reciprocal and shift by MAG_W plus the divisor's bit length.
  localparam int unsigned DIV_SRC = (FULL_SCALE * 3) / 2;
  localparam int unsigned SH_SRC  = M_W + $clog2(DIV_SRC);
  localparam int unsigned SH_MST  = M_W + $clog2(FULL_SCALE);
  localparam logic [63:0] RCP_SRC_FULL =
    ((64'd1 << SH_SRC) + 64'(DIV_SRC) - 64'd1) / 64'(DIV_SRC);
  localparam logic [63:0] RCP_MST_FULL =
    ((64'd1 << SH_MST) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam logic [R_W-1:0] RCP_SRC = RCP_SRC_FULL[R_W-1:0];
  localparam logic [R_W-1:0] RCP_MST = RCP_MST_FULL[R_W-1:0];
  // A master product at or above this limit clamps to full scale.
  localparam logic [P_W-1:0] OVF_LIM = P_W'(64'(FULL_SCALE) * 64'(FULL_SCALE + 1));
  localparam logic [D_W-1:0] FS_VAL  = D_W'(FULL_SCALE);

  logic [S_W-1:0]                     a_mag;
  logic                               a_neg;
  logic [svpm_pkg::VOL_W-1:0]         b_val;
  logic [svpm_pkg::SIDE_W-1:0]        item_side;
  logic                               item_muted;
  logic                               item_is_last;
  logic [P_W-1:0]                     mag;
  logic [Q_W-1:0]                     quo;
  logic                               ovf;
  logic signed [S_W-1:0]              left_sum;
  logic signed [S_W-1:0]              right_sum;
  logic [D_W-1:0]                     res_l;
  logic [D_W-1:0]                     res_r;
  logic [D_W-1:0]                     out_l;
  logic [D_W-1:0]                     out_r;
  logic [svpm_pkg::VOLIDX_W-1:0]      vol_l_idx;
  logic [svpm_pkg::VOLIDX_W-1:0]      vol_r_idx;
  logic [svpm_pkg::VOL_W-1:0]         vol_l_val;
  logic [svpm_pkg::VOL_W-1:0]         vol_r_val;

  logic signed [D_W-1:0]              samp;
  logic signed [S_W-1:0]              samp_ext;
  logic [S_W-1:0]                     abs_samp;
  logic signed [S_W-1:0]              sum_sel;
  logic [S_W-1:0]                     abs_sum;
  logic [R_W-1:0]                     rcp_sel;
  logic [X_W-1:0]                     rcp_prod;
  logic [Q_W-1:0]                     quo_next;
  logic signed [S_W-1:0]              contrib;
  logic [D_W-1:0]                     res_mag;
  logic [D_W-1:0]                     res_val;
  logic signed [svpm_pkg::BAL_W-1:0]  bal_c;
  logic [2:0]                         bal_mag;
  logic [2:0]                         att;
  logic [7:0]                         att_prod;
  logic [15:0]                        att_scaled;
  logic [svpm_pkg::VOLIDX_W-1:0]      att_idx;

  assign samp     = $signed(item_data[D_W-1:0]);
  assign samp_ext = S_W'(samp);
  assign abs_samp = samp[D_W-1] ? S_W'(-samp_ext) : S_W'(samp_ext);

  assign sum_sel  = cmd.side_r ? right_sum : left_sum;
  assign abs_sum  = sum_sel[S_W-1] ? S_W'(-sum_sel) : S_W'(sum_sel);

  assign rcp_sel  = cmd.mst ? RCP_MST : RCP_SRC;
  assign rcp_prod = X_W'(mag[M_W-1:0]) * X_W'(rcp_sel);
  assign quo_next = cmd.mst ? Q_W'(rcp_prod >> SH_MST) : Q_W'(rcp_prod >> SH_SRC);

  assign contrib  = a_neg ? -$signed(S_W'(quo)) : $signed(S_W'(quo));
  assign res_mag  = ovf ? FS_VAL : quo[D_W-1:0];
  assign res_val  = a_neg ? D_W'(-res_mag) : res_mag;

  // Master index per side from the balance setting.
  assign bal_c      = (balance < svpm_pkg::BAL_MIN) ? svpm_pkg::BAL_MIN :
                      (balance > svpm_pkg::BAL_MAX) ? svpm_pkg::BAL_MAX : balance;
  assign bal_mag    = bal_c[svpm_pkg::BAL_W-1] ? 3'(-bal_c) : 3'(bal_c);
  assign att        = 3'(svpm_pkg::BAL_STEPS - bal_mag);
  assign att_prod   = 8'(att) * 8'(master_volume);
  assign att_scaled = 16'(att_prod) * svpm_pkg::DIV6_RECIP;
  assign att_idx    = svpm_pkg::VOLIDX_W'(att_scaled >> svpm_pkg::DIV6_SHIFT);

  always_ff @(posedge clk) begin
    vol_l_idx <= bal_c[svpm_pkg::BAL_W-1] ? master_volume : att_idx;
    vol_r_idx <= bal_c[svpm_pkg::BAL_W-1] ? att_idx : master_volume;
    vol_l_val <= VOL_TAB[vol_l_idx];
    vol_r_val <= VOL_TAB[vol_r_idx];
  end

  // Operand, product and quotient registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      a_mag        <= abs_samp;
      a_neg        <= samp[D_W-1];
      b_val        <= VOL_TAB[item_data[svpm_pkg::ITEM_W-1:D_W]];
      item_side    <= item_user[svpm_pkg::SIDE_W-1:0];
      item_muted   <= item_user[svpm_pkg::SIDE_W];
      item_is_last <= item_last;
    end else if (cmd.load_sum) begin
      a_mag <= abs_sum;
      a_neg <= sum_sel[S_W-1];
      b_val <= cmd.side_r ? vol_r_val : vol_l_val;
    end
    if (cmd.mul) begin
      mag <= P_W'(a_mag) * P_W'(b_val);
    end
    if (cmd.div) begin
      quo <= quo_next;
      ovf <= (mag >= OVF_LIM);
    end
    if (cmd.store) begin
      if (cmd.side_r) begin
        res_r <= res_val;
      end else begin
        res_l <= res_val;
      end
    end
  end

  // Sums wrap as two's complement and clear once the pair has been issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (cmd.emit) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (cmd.acc && !item_muted) begin
      if (item_side != svpm_pkg::SIDE_LEFT)  right_sum <= right_sum + contrib;
      if (item_side != svpm_pkg::SIDE_RIGHT) left_sum  <= left_sum + contrib;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_l <= mute_all ? '0 : res_l;
      out_r <= mute_all ? '0 : res_r;
    end
  end

  assign m_tdata = {out_r, out_l};
  assign stat    = '{last_item: item_is_last, out_stall: m_tvalid && !m_tready};

endmodule

`default_nettype wire

FILE: hdl/stereo_volume_pan_mixer.sv
// Top level of the stereo volume and pan mixer: configuration registers,
// sequencer and datapath. Depends on svpm_pkg, svpm_ctrl, svpm_datapath and
// the assertion macros in stereo_volume_pan_mixer_assert.svh.
//
// Usage. Each input transaction on the s_ group carries one source sample with
// its log volume (tdata), its side and mute flag (tuser) and tlast on the final
// source of an output frame. Each contribution is the sample times the volume
// table entry, divided by one and a half full scale and truncated towards zero.
// On the transaction with tlast the block scales both sums by the master volume,
// split by the balance setting, clamps to plus or minus full scale and offers
// one stereo pair on the m_ group.
// An item passes through the multiply, reciprocal divide and accumulate steps,
// which share one operand path; the next item is taken in the accumulate step
// unless the current one has tlast. An item with tlast holds the input while
// both sides pass through the master load, multiply, divide and store steps and
// the pair is emitted; the emit step waits while the output register is full.
// The output register holds a pair while the receiver stalls, and input keeps
// being accepted meanwhile; only the next pair waits for the register to free.
// Synchronous reset clears the sums and the output valid, and sets master
// volume 29, balance 0 and global mute off. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_volume_pan_mixer_assert.svh"

module stereo_volume_pan_mixer #(
  parameter int unsigned FULL_SCALE = 32767
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // tdata: sample [15:0], source_volume [20:16], zero fill [23:21]
  input  wire logic [svpm_pkg::IN_TDATA_W-1:0]    s_tdata,
  // tuser: source_side [1:0], source_muted [2]
  input  wire logic [svpm_pkg::IN_TUSER_W-1:0]    s_tuser,
  input  wire logic                               s_tlast,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // tdata: left [15:0], right [31:16]
  output logic [svpm_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic                               cfg_wen,
  input  wire logic [svpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [svpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic signed [svpm_pkg::SAMPLE_W:0] FS_POS = (svpm_pkg::SAMPLE_W + 1)'(FULL_SCALE);
  localparam logic signed [svpm_pkg::SAMPLE_W:0] FS_NEG = -FS_POS;

  logic [svpm_pkg::VOLIDX_W-1:0]      master_volume;
  logic signed [svpm_pkg::BAL_W-1:0]  balance;
  logic                               mute_all;
  svpm_pkg::cmd_t                     cmd;
  svpm_pkg::stat_t                    stat;
  logic                               out_in_range;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= svpm_pkg::MASTER_VOLUME_RESET;
      balance       <= '0;
      mute_all      <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        svpm_pkg::REG_MASTER_VOLUME: master_volume <= cfg_data;
        svpm_pkg::REG_BALANCE:       balance       <= $signed(cfg_data[svpm_pkg::BAL_W-1:0]);
        svpm_pkg::REG_MUTE_ALL:      mute_all      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  svpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svpm_datapath #(
    .FULL_SCALE (FULL_SCALE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item_data     (s_tdata[svpm_pkg::ITEM_W-1:0]),
    .item_user     (s_tuser),
    .item_last     (s_tlast),
    .master_volume (master_volume),
    .balance       (balance),
    .mute_all      (mute_all),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

  // Both halves of the offered pair lie within plus or minus full scale.
  assign out_in_range = ($signed(m_tdata[15:0]) <= FS_POS) &&
                        ($signed(m_tdata[15:0]) >= FS_NEG) &&
                        ($signed(m_tdata[31:16]) <= FS_POS) &&
                        ($signed(m_tdata[31:16]) >= FS_NEG);

  // The block takes no item right after a transaction, as it is busy with the one taken.
  `SVPM_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  // A pair is only offered after the sequencer issued it.
  `SVPM_ASSERT_IMPLIES(a_valid_from_emit, clk, rst, $rose(m_tvalid), $past(cmd.emit))
  // A new pair never overwrites one the receiver has not taken.
  `SVPM_ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.emit, !(m_tvalid && !m_tready))
  // Global mute gives a silent pair.
  `SVPM_ASSERT_NEXT(a_mute_zero, clk, rst, cmd.emit && mute_all, m_tdata == '0)
  // Both outputs stay within plus or minus full scale.
  `SVPM_ASSERT_IMPLIES(a_clamped, clk, rst, m_tvalid, out_in_range)

endmodule

`default_nettype wire

FILE: tb/sv/tb_stereo_volume_pan_mixer.sv
// Self-checking testbench for the stereo volume and pan mixer: it drives source
// transactions and register writes and checks every stereo pair against its own predictor.
// Depends on svpm_pkg and the stereo_volume_pan_mixer RTL only.
`timescale 1ns / 1ps

module tb_stereo_volume_pan_mixer;

  localparam int unsigned FULL_SCALE = 32767;
  // Contributions are divided by one and a half full scale, truncated.
  localparam longint SOURCE_DIV = longint'((FULL_SCALE * 3) / 2);
  // A transaction with tlast shows its pair after the master scaling of both sides; allow some margin.
  localparam int DRAIN_CYCLES = 20;

  // Side codes that the package does not name: both sides, and the spare code
  // that the block also routes to both sides.
  localparam logic [svpm_pkg::SIDE_W-1:0] SIDE_BOTH  = 2'd0;
  localparam logic [svpm_pkg::SIDE_W-1:0] SIDE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [svpm_pkg::SAMPLE_W-1:0] sample;
    logic [svpm_pkg::VOLIDX_W-1:0]        volume;
    logic [svpm_pkg::SIDE_W-1:0]          side;
    logic                                 muted;
    logic                                 last;
  } source_item_t;

  // Right in the upper half, so that the struct lines up with m_tdata.
  typedef struct packed {
    logic signed [svpm_pkg::SAMPLE_W-1:0] right;
    logic signed [svpm_pkg::SAMPLE_W-1:0] left;
  } stereo_pair_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic [svpm_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
  logic [svpm_pkg::IN_TUSER_W-1:0]     s_tuser = '0;
  logic                                s_tlast = 1'b0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [svpm_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic                                cfg_wen = 1'b0;
  logic [svpm_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [svpm_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  stereo_volume_pan_mixer #(.FULL_SCALE(FULL_SCALE)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: gain table, register copies and the two running sums.
  longint                        gain_tab [svpm_pkg::NUM_VOL];
  logic [svpm_pkg::VOLIDX_W-1:0] master_idx = svpm_pkg::MASTER_VOLUME_RESET;
  logic signed [3:0]             pan_bal = '0;
  logic                          global_mute = 1'b0;
  logic [31:0]                   left_mix = '0;
  logic [31:0]                   right_mix = '0;

  stereo_pair_t pending_pairs [$];
  int           fail_count = 0;

  // Traffic shaping, set by the tests.
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_hold_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("stereo_volume_pan_mixer: mismatch");
    $finish;
  end

  // 1.5 dB log table: top entry is full scale, each step down divides by the
  // step ratio in Q16 with rounding to nearest; entry zero is silence.
  function automatic void build_gain_table();
    longint unsigned acc;
    acc = longint'(FULL_SCALE) << 16;
    gain_tab[0] = 0;
    for (int k = svpm_pkg::NUM_VOL - 1; k >= 1; k--) begin
      gain_tab[k] = longint'((acc + 64'd32768) >> 16);
      acc = (acc * 64'd1000000000 + 64'd594251113) / 64'd1188502227;
    end
  endfunction

  // Master scale of one side, truncated towards zero, then clamped.
  function automatic logic [svpm_pkg::SAMPLE_W-1:0] master_scale(input logic [31:0] sum,
                                                                 input int idx);
    longint s;
    longint v;
    s = longint'($signed(sum));
    v = (s * gain_tab[idx]) / longint'(FULL_SCALE);
    if (v > longint'(FULL_SCALE)) v = FULL_SCALE;
    else if (v < -longint'(FULL_SCALE)) v = -longint'(FULL_SCALE);
    return v[svpm_pkg::SAMPLE_W-1:0];
  endfunction

  // Adds one accepted source to the sums and, on tlast, queues the pair.
  function automatic void mix_source(input source_item_t it);
    longint contrib;
    int bal;
    int vol_l;
    int vol_r;
    stereo_pair_t pair;
    if (!it.muted) begin
      contrib = (longint'(it.sample) * gain_tab[it.volume]) / SOURCE_DIV;
      if (it.side != svpm_pkg::SIDE_LEFT) right_mix += contrib[31:0];
      if (it.side != svpm_pkg::SIDE_RIGHT) left_mix += contrib[31:0];
    end
    if (it.last) begin
      bal = pan_bal;
      if (bal < -6) bal = -6;
      else if (bal > 6) bal = 6;
      vol_l = master_idx;
      vol_r = master_idx;
      if (bal < 0) vol_r = (6 + bal) * int'(master_idx) / 6;
      else vol_l = (6 - bal) * int'(master_idx) / 6;
      if (global_mute) begin
        pair = '0;
      end else begin
        pair.left = master_scale(left_mix, vol_l);
        pair.right = master_scale(right_mix, vol_r);
      end
      pending_pairs.push_back(pair);
      left_mix = '0;
      right_mix = '0;
    end
  endfunction

  function automatic source_item_t make_source(input int sample, input int volume,
                                               input logic [svpm_pkg::SIDE_W-1:0] side,
                                               input bit muted, input bit last);
    source_item_t it;
    it.sample = sample[svpm_pkg::SAMPLE_W-1:0];
    it.volume = volume[svpm_pkg::VOLIDX_W-1:0];
    it.side = side;
    it.muted = muted;
    it.last = last;
    return it;
  endfunction

  // Random source with full-scale samples now and then; few muted ones.
  function automatic source_item_t random_source(input bit last);
    source_item_t it;
    it.sample = svpm_pkg::SAMPLE_W'($urandom());
    case ($urandom_range(0, 9))
      0: it.sample = 16'sh7fff;
      1: it.sample = 16'sh8000;
      default: ;
    endcase
    it.volume = ($urandom_range(0, 3) == 0) ? svpm_pkg::VOLIDX_W'($urandom_range(28, 31))
                                            : svpm_pkg::VOLIDX_W'($urandom_range(0, 31));
    it.side = svpm_pkg::SIDE_W'($urandom_range(0, 3));
    it.muted = ($urandom_range(0, 7) == 0);
    it.last = last;
    return it;
  endfunction

  // Offers one source transaction and waits for the handshake. Valid is left
  // high afterwards; the next call or quiesce decides what happens to it.
  task automatic send_source(input source_item_t it);
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tdata <= svpm_pkg::IN_TDATA_W'({it.volume, it.sample});
    s_tuser <= {it.muted, it.side};
    s_tlast <= it.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    mix_source(it);
  endtask

  // Stops offering input and waits until every pair has come back, plus the
  // block's own latency, so that register writes find it idle.
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [svpm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [svpm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      svpm_pkg::REG_MASTER_VOLUME: master_idx = value[svpm_pkg::VOLIDX_W-1:0];
      svpm_pkg::REG_BALANCE:       pan_bal = value[3:0];
      svpm_pkg::REG_MUTE_ALL:      global_mute = value[0];
      default: ;
    endcase
  endtask

  // Writes all three registers; the unused upper data bits carry noise.
  task automatic set_mix_config(input int master, input int bal, input bit mute);
    write_reg(svpm_pkg::REG_MASTER_VOLUME, svpm_pkg::CFG_DATA_W'(master));
    write_reg(svpm_pkg::REG_BALANCE, {1'($urandom()), 4'(bal)});
    write_reg(svpm_pkg::REG_MUTE_ALL, {4'($urandom()), mute});
  endtask

  // Sends whole frames of random sources until at least count have gone.
  task automatic send_frames(input int count, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) send_source(random_source(i == len - 1));
      sent += len;
    end
  endtask

  // Receiver: bursts of stall, and a long hold-off when a test asks for one.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Each pair taken by the receiver is checked against the oldest prediction.
  always @(posedge clk) begin
    stereo_pair_t got;
    stereo_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_pairs.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected pair left %0d right %0d", $realtime, got.left, got.right);
      end else begin
        want = pending_pairs.pop_front();
        if (got.left !== want.left || got.right !== want.right) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: pair differs, expected left %0d right %0d, got left %0d right %0d",
                     $realtime, want.left, want.right, got.left, got.right);
        end
      end
    end
  end

  // Full-scale samples, silence, every side code, a muted source, truncation
  // of tiny values and frames that drive both sums into the clamp.
  task automatic test_directed_edges();
    send_source(make_source(32767, 31, SIDE_BOTH, 0, 1));
    send_source(make_source(-32768, 31, SIDE_BOTH, 0, 1));
    send_source(make_source(-32768, 0, SIDE_BOTH, 0, 1));
    send_source(make_source(12345, 1, svpm_pkg::SIDE_LEFT, 0, 1));
    send_source(make_source(-12345, 30, svpm_pkg::SIDE_RIGHT, 0, 1));
    send_source(make_source(20000, 31, SIDE_SPARE, 0, 1));
    send_source(make_source(32767, 31, SIDE_BOTH, 1, 1));
    for (int i = 0; i < 4; i++) send_source(make_source(32767, 31, SIDE_BOTH, 0, i == 3));
    for (int i = 0; i < 4; i++) send_source(make_source(-32768, 31, SIDE_SPARE, 0, i == 3));
    send_source(make_source(-1, 31, svpm_pkg::SIDE_LEFT, 0, 0));
    send_source(make_source(1, 31, svpm_pkg::SIDE_RIGHT, 0, 1));
    send_source(make_source(21845, 16, svpm_pkg::SIDE_LEFT, 1, 0));
    send_source(make_source(-10923, 15, svpm_pkg::SIDE_RIGHT, 0, 1));
    quiesce();
  endtask

  // Register extremes: silent master, full master, balance at both limits and
  // beyond them, small balance steps, and global mute on then off again.
  task automatic test_register_extremes();
    int settings [10][3] = '{'{0, 0, 0}, '{31, 0, 0}, '{31, -6, 0}, '{31, 6, 0},
                             '{31, -8, 0}, '{31, 7, 0}, '{17, -1, 0}, '{17, 1, 0},
                             '{31, 0, 1}, '{29, 0, 0}};
    for (int s = 0; s < 10; s++) begin
      set_mix_config(settings[s][0], settings[s][1], settings[s][2] != 0);
      send_frames(8, 4);
      quiesce();
    end
  endtask

  // Bulk random traffic over a run of register settings.
  task automatic test_random_mixing();
    for (int phase = 0; phase < 7; phase++) begin
      set_mix_config($urandom_range(0, 31), $urandom_range(0, 15) - 8,
                     $urandom_range(0, 5) == 0);
      send_frames(210, 6);
      quiesce();
    end
  endtask

  // The receiver holds off long enough for the output register to fill and
  // the input to stall, while single-source frames keep being offered.
  task automatic test_output_backpressure();
    set_mix_config(31, 0, 0);
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 200;
    send_frames(30, 1);
    quiesce();
    tx_gaps_on = 1'b1;
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    set_mix_config(30, -3, 0);
    send_frames(150, 5);
    quiesce();
  endtask

  initial begin
    build_gain_table();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_register_extremes();
    test_random_mixing();
    test_output_backpressure();
    test_full_rate();
    if (fail_count == 0) begin
      $display("stereo_volume_pan_mixer: match");
    end else begin
      $display("stereo_volume_pan_mixer: mismatch");
    end
    $finish;
  end

endmodule
